// ===== rtl/core/ascon_pkg.sv =====
// Shared types, codes and helper functions for the Ascon-128 AEAD engine.
// Used by rtl/core/ascon128_aead_engine.sv; depends on nothing else.
`default_nettype none

package ascon_pkg;

    typedef logic [4:0][63:0] t_state;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  bytes;
        logic [1:0]  kind;
        logic        last;
        logic        ok;
    } t_result;

    localparam logic [1:0] FN_BEGIN = 2'd0;
    localparam logic [1:0] FN_AD    = 2'd1;
    localparam logic [1:0] FN_TEXT  = 2'd2;
    localparam logic [1:0] FN_TAG   = 2'd3;

    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_TAG     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;
    localparam logic [1:0] KIND_SEQERR  = 2'd3;

    localparam logic [2:0] CFG_KEY_HIGH   = 3'd0;
    localparam logic [2:0] CFG_KEY_LOW    = 3'd1;
    localparam logic [2:0] CFG_NONCE_HIGH = 3'd2;
    localparam logic [2:0] CFG_NONCE_LOW  = 3'd3;
    localparam logic [2:0] CFG_DECRYPT    = 3'd4;

    localparam logic [63:0] ASCON_IV = 64'h8040_0c06_0000_0000;
    localparam logic [3:0]  RATE_BYTES = 4'd8;
    localparam logic [3:0]  LAST_ROUND = 4'd11;
    localparam logic [3:0]  P12_START  = 4'd0;
    localparam logic [3:0]  P6_START   = 4'd6;

    // Mask that keeps the top n bytes of a word.
    function automatic logic [63:0] top_mask(input logic [2:0] n);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            if (3'(k) < n) begin
                m[63 - 8 * k -: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic [63:0] pad_word(input logic [2:0] n);
        return 64'h8000_0000_0000_0000 >> {n, 3'b000};
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // One Ascon round; the constant for round i is {15 - i, i}.
    function automatic t_state ascon_round(input t_state s, input logic [3:0] i);
        logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, 4'(4'd15 - i), i};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        s[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        s[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        s[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
        s[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        s[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ascon128_aead_engine.sv =====
// Ascon-128 AEAD engine: one round unit shared by all permutations under a sequencer.
// Depends on rtl/core/ascon_pkg.sv.
//
// Channel  Direction  Beat holds
// s        in         tdata: in_data[63:0], tail_bytes[66:64]; tuser: func; tlast: last
// m        out        tdata: out_data[63:0], out_bytes[67:64], tag_ok[68]; tuser: out_kind
// cfg      in         index and 64-bit data of one configuration register
//
// The round unit does one round per cycle. A begin beat or a final text beat is loaded and
// then runs twelve rounds; other data beats run six rounds.
// Tag words follow a final encrypt beat as soon as the result buffer frees.
// Reset is synchronous and clears all control state. A stalled output holds one
// result in the output register and one in a buffer; input waits while the buffer is full.
`default_nettype none

module ascon128_aead_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,   // in_data[63:0], tail_bytes[66:64], zero
    input  wire logic [1:0]  i_s_tuser,   // func[1:0]
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // out_data[63:0], out_bytes[67:64], tag_ok[68]
    output logic [1:0]       o_m_tuser,   // out_kind[1:0]
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PERM = 2'd1;
    localparam logic [1:0] S_TAG0 = 2'd2;
    localparam logic [1:0] S_TAG1 = 2'd3;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_READY   = 3'd1;
    localparam logic [2:0] PH_AD      = 3'd2;
    localparam logic [2:0] PH_AD_DONE = 3'd3;
    localparam logic [2:0] PH_TEXT    = 3'd4;
    localparam logic [2:0] PH_TAG     = 3'd5;

    logic [63:0] r_key_high, r_key_low, r_nonce_high, r_nonce_low;
    logic        r_decrypt;

    ascon_pkg::t_state  r_x, n_x, w_round;
    ascon_pkg::t_result r_pend, n_pend, r_out;
    logic [1:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic [3:0] r_rnd, n_rnd;
    logic       r_post_key, n_post_key;
    logic       r_post_tags, n_post_tags;
    logic       r_mismatch, n_mismatch;
    logic       r_seen, n_seen;
    logic       r_pend_valid, n_pend_valid;
    logic       r_out_valid;

    logic        w_accept, w_out_free, w_drain, w_last;
    logic [1:0]  w_func;
    logic [2:0]  w_tail;
    logic [63:0] w_data, w_mask, w_dm, w_txt;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE) && !r_pend_valid;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_func      = i_s_tuser;
    assign w_data      = i_s_tdata[63:0];
    assign w_tail      = i_s_tdata[66:64];
    assign w_last      = i_s_tlast;
    assign w_mask      = w_last ? ascon_pkg::top_mask(w_tail) : '0;
    assign w_dm        = w_data & w_mask;
    assign w_round     = ascon_pkg::ascon_round(r_x, r_rnd);

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_drain     = r_pend_valid && w_out_free;

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {3'b000, r_out.ok, r_out.bytes, r_out.data};
    assign o_m_tuser   = r_out.kind;
    assign o_m_tlast   = r_out.last;

    always_comb begin
        n_x          = r_x;
        n_state      = r_state;
        n_phase      = r_phase;
        n_rnd        = r_rnd;
        n_post_key   = r_post_key;
        n_post_tags  = r_post_tags;
        n_mismatch   = r_mismatch;
        n_seen       = r_seen;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid && !w_drain;
        w_txt        = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_func == ascon_pkg::FN_BEGIN) begin
                        n_x         = {r_nonce_low, r_nonce_high, r_key_low, r_key_high,
                                       ascon_pkg::ASCON_IV};
                        n_rnd       = ascon_pkg::P12_START;
                        n_post_key  = 1'b1;
                        n_post_tags = 1'b0;
                        n_phase     = PH_READY;
                        n_mismatch  = 1'b0;
                        n_seen      = 1'b0;
                        n_state     = S_PERM;
                    end else if (w_func == ascon_pkg::FN_AD &&
                                 (r_phase == PH_READY || r_phase == PH_AD)) begin
                        if (w_last) begin
                            n_x[0]  = r_x[0] ^ w_dm ^ ascon_pkg::pad_word(w_tail);
                            n_phase = PH_AD_DONE;
                        end else begin
                            n_x[0]  = r_x[0] ^ w_data;
                            n_phase = PH_AD;
                        end
                        n_rnd       = ascon_pkg::P6_START;
                        n_post_key  = 1'b0;
                        n_post_tags = 1'b0;
                        n_state     = S_PERM;
                    end else if (w_func == ascon_pkg::FN_TEXT &&
                                 (r_phase == PH_READY || r_phase == PH_AD_DONE ||
                                  r_phase == PH_TEXT)) begin
                        if (r_phase != PH_TEXT) begin
                            n_x[4] = r_x[4] ^ 64'd1;
                        end
                        n_phase = PH_TEXT;
                        n_state = S_PERM;
                        if (!w_last) begin
                            if (r_decrypt) begin
                                w_txt  = r_x[0] ^ w_data;
                                n_x[0] = w_data;
                            end else begin
                                w_txt  = r_x[0] ^ w_data;
                                n_x[0] = w_txt;
                            end
                            n_rnd       = ascon_pkg::P6_START;
                            n_post_key  = 1'b0;
                            n_post_tags = 1'b0;
                            n_pend      = '{data: w_txt, bytes: ascon_pkg::RATE_BYTES,
                                            kind: ascon_pkg::KIND_TEXT, last: 1'b0,
                                            ok: 1'b0};
                        end else begin
                            w_txt = (r_x[0] ^ w_dm) & w_mask;
                            if (r_decrypt) begin
                                n_x[0] = ((r_x[0] & ~w_mask) | w_dm)
                                         ^ ascon_pkg::pad_word(w_tail);
                                n_phase    = PH_TAG;
                                n_mismatch = 1'b0;
                                n_seen     = 1'b0;
                            end else begin
                                n_x[0] = r_x[0] ^ w_dm ^ ascon_pkg::pad_word(w_tail);
                                n_phase    = PH_IDLE;
                                n_mismatch = 1'b0;
                                n_seen     = 1'b0;
                            end
                            n_x[1]      = r_x[1] ^ r_key_high;
                            n_x[2]      = r_x[2] ^ r_key_low;
                            n_rnd       = ascon_pkg::P12_START;
                            n_post_key  = 1'b1;
                            n_post_tags = !r_decrypt;
                            n_pend      = '{data: w_txt, bytes: {1'b0, w_tail},
                                            kind: ascon_pkg::KIND_TEXT, last: 1'b0,
                                            ok: 1'b0};
                        end
                        n_pend_valid = 1'b1;
                    end else if (w_func == ascon_pkg::FN_TAG && r_phase == PH_TAG) begin
                        if (!r_seen) begin
                            n_mismatch = (w_data != r_x[3]);
                            n_seen     = 1'b1;
                        end else begin
                            n_pend = '{data: '0, bytes: '0,
                                       kind: ascon_pkg::KIND_VERDICT, last: 1'b1,
                                       ok: !(r_mismatch || (w_data != r_x[4]))};
                            n_pend_valid = 1'b1;
                            n_phase      = PH_IDLE;
                            n_mismatch   = 1'b0;
                            n_seen       = 1'b0;
                        end
                    end else begin
                        n_pend = '{data: '0, bytes: '0, kind: ascon_pkg::KIND_SEQERR,
                                   last: 1'b1, ok: 1'b0};
                        n_pend_valid = 1'b1;
                        n_phase      = PH_IDLE;
                        n_mismatch   = 1'b0;
                        n_seen       = 1'b0;
                    end
                end
            end
            S_PERM: begin
                n_x   = w_round;
                n_rnd = r_rnd + 4'd1;
                if (r_rnd == ascon_pkg::LAST_ROUND) begin
                    if (r_post_key) begin
                        n_x[3] = w_round[3] ^ r_key_high;
                        n_x[4] = w_round[4] ^ r_key_low;
                    end
                    n_state = r_post_tags ? S_TAG0 : S_IDLE;
                end
            end
            S_TAG0: begin
                if (!r_pend_valid) begin
                    n_pend = '{data: r_x[3], bytes: ascon_pkg::RATE_BYTES,
                               kind: ascon_pkg::KIND_TAG, last: 1'b0, ok: 1'b0};
                    n_pend_valid = 1'b1;
                    n_state      = S_TAG1;
                end
            end
            S_TAG1: begin
                if (!r_pend_valid) begin
                    n_pend = '{data: r_x[4], bytes: ascon_pkg::RATE_BYTES,
                               kind: ascon_pkg::KIND_TAG, last: 1'b1, ok: 1'b0};
                    n_pend_valid = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_nonce_high <= '0;
            r_nonce_low  <= '0;
            r_decrypt    <= 1'b0;
            r_x          <= '0;
            r_state      <= S_IDLE;
            r_phase      <= PH_IDLE;
            r_rnd        <= '0;
            r_post_key   <= 1'b0;
            r_post_tags  <= 1'b0;
            r_mismatch   <= 1'b0;
            r_seen       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ascon_pkg::CFG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                    ascon_pkg::CFG_KEY_LOW:    r_key_low    <= i_cfg_data;
                    ascon_pkg::CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data;
                    ascon_pkg::CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                    ascon_pkg::CFG_DECRYPT:    r_decrypt    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_x          <= n_x;
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_rnd        <= n_rnd;
            r_post_key   <= n_post_key;
            r_post_tags  <= n_post_tags;
            r_mismatch   <= n_mismatch;
            r_seen       <= n_seen;
            r_pend_valid <= n_pend_valid;
            if (w_drain) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (w_drain) begin
            r_out <= r_pend;
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("input ready while the round unit is busy");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PERM) |-> (r_rnd <= ascon_pkg::LAST_ROUND))
        else $error("round counter out of range");

    a_begin_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == ascon_pkg::FN_BEGIN) |=> (r_state == S_PERM))
        else $error("begin beat did not start the permutation");

    a_tags_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAG0 || r_state == S_TAG1) |-> (r_phase == PH_IDLE))
        else $error("tag words emitted while a message is open");

endmodule

`default_nettype wire

// ===== verif/ascon_aead_checker.sv =====
// Scoreboard for the Ascon-128 AEAD engine: it mirrors the engine state, predicts the result
// beats of every accepted input beat and compares them with the output channel in order.
// Depends on rtl/core/ascon_pkg.sv for the code constants and the result type.
module ascon_aead_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // in_data[63:0], tail_bytes[66:64], zero
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,   // out_data[63:0], out_bytes[67:64], tag_ok[68]
    input  logic [1:0]  i_m_tuser,   // out_kind[1:0]
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_READY,
        PH_AD,
        PH_AD_DONE,
        PH_TEXT,
        PH_TAG
    } t_msg_phase;

    logic [63:0]        key_hi;
    logic [63:0]        key_lo;
    logic [63:0]        nonce_hi;
    logic [63:0]        nonce_lo;
    logic               decrypt_on;
    ascon_pkg::t_state  lanes;
    t_msg_phase         phase;
    logic               tag_differs;
    logic               first_tag_seen;
    ascon_pkg::t_result due_results[$];
    int                 mismatch_count = 0;

    function automatic logic [63:0] ror(input logic [63:0] v, input int n);
        logic [127:0] w;
        w = {v, v} >> n;
        return w[63:0];
    endfunction

    function automatic logic [63:0] keep_top(input logic [2:0] n);
        return (n == 3'd0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
    endfunction

    function automatic logic [63:0] pad_bit(input logic [2:0] n);
        return 64'h80 << (56 - 8 * n);
    endfunction

    // Runs the last 'rounds' rounds of the twelve-round schedule.
    function automatic ascon_pkg::t_state ascon_permute(input ascon_pkg::t_state s,
                                                        input int rounds);
        logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        logic [31:0] r;
        logic [7:0]  rc;
        for (r = 12 - rounds; r < 12; r++) begin
            rc = 8'hf0 - 8'h0f * r[7:0];
            x0 = s[0] ^ s[4];
            x1 = s[1];
            x2 = s[2] ^ {56'd0, rc} ^ s[1];
            x3 = s[3];
            x4 = s[4] ^ s[3];
            t0 = ~x0 & x1;
            t1 = ~x1 & x2;
            t2 = ~x2 & x3;
            t3 = ~x3 & x4;
            t4 = ~x4 & x0;
            x0 = x0 ^ t1;
            x1 = x1 ^ t2;
            x2 = x2 ^ t3;
            x3 = x3 ^ t4;
            x4 = x4 ^ t0;
            x1 = x1 ^ x0;
            x0 = x0 ^ x4;
            x3 = x3 ^ x2;
            x2 = ~x2;
            s[0] = x0 ^ ror(x0, 19) ^ ror(x0, 28);
            s[1] = x1 ^ ror(x1, 61) ^ ror(x1, 39);
            s[2] = x2 ^ ror(x2, 1) ^ ror(x2, 6);
            s[3] = x3 ^ ror(x3, 10) ^ ror(x3, 17);
            s[4] = x4 ^ ror(x4, 7) ^ ror(x4, 41);
        end
        return s;
    endfunction

    function automatic void owe(input logic [63:0] d, input logic [3:0] b, input logic [1:0] k,
                                input logic l, input logic ok);
        ascon_pkg::t_result res;
        res.data = d;
        res.bytes = b;
        res.kind = k;
        res.last = l;
        res.ok = ok;
        due_results.push_back(res);
    endfunction

    function automatic void drop_message();
        phase = PH_IDLE;
        tag_differs = 1'b0;
        first_tag_seen = 1'b0;
    endfunction

    function automatic void ascon_absorb(input logic [1:0] fn, input logic [63:0] data,
                                         input logic [2:0] tail, input logic lst);
        logic [63:0] m;
        logic [63:0] d;
        logic [63:0] txt;
        if (fn == ascon_pkg::FN_BEGIN) begin
            lanes[0] = ascon_pkg::ASCON_IV;
            lanes[1] = key_hi;
            lanes[2] = key_lo;
            lanes[3] = nonce_hi;
            lanes[4] = nonce_lo;
            lanes = ascon_permute(lanes, 12);
            lanes[3] = lanes[3] ^ key_hi;
            lanes[4] = lanes[4] ^ key_lo;
            drop_message();
            phase = PH_READY;
        end else if (fn == ascon_pkg::FN_AD && (phase == PH_READY || phase == PH_AD)) begin
            if (lst) begin
                lanes[0] = lanes[0] ^ (data & keep_top(tail)) ^ pad_bit(tail);
                phase = PH_AD_DONE;
            end else begin
                lanes[0] = lanes[0] ^ data;
                phase = PH_AD;
            end
            lanes = ascon_permute(lanes, 6);
        end else if (fn == ascon_pkg::FN_TEXT &&
                     (phase == PH_READY || phase == PH_AD_DONE || phase == PH_TEXT)) begin
            if (phase != PH_TEXT) begin
                lanes[4] = lanes[4] ^ 64'd1;
            end
            phase = PH_TEXT;
            if (!lst) begin
                if (decrypt_on) begin
                    txt = lanes[0] ^ data;
                    lanes[0] = data;
                end else begin
                    lanes[0] = lanes[0] ^ data;
                    txt = lanes[0];
                end
                lanes = ascon_permute(lanes, 6);
                owe(txt, ascon_pkg::RATE_BYTES, ascon_pkg::KIND_TEXT, 1'b0, 1'b0);
            end else begin
                m = keep_top(tail);
                d = data & m;
                if (decrypt_on) begin
                    txt = (lanes[0] ^ d) & m;
                    lanes[0] = (lanes[0] & ~m) | d;
                end else begin
                    lanes[0] = lanes[0] ^ d;
                    txt = lanes[0] & m;
                end
                lanes[0] = lanes[0] ^ pad_bit(tail);
                lanes[1] = lanes[1] ^ key_hi;
                lanes[2] = lanes[2] ^ key_lo;
                lanes = ascon_permute(lanes, 12);
                lanes[3] = lanes[3] ^ key_hi;
                lanes[4] = lanes[4] ^ key_lo;
                owe(txt, {1'b0, tail}, ascon_pkg::KIND_TEXT, 1'b0, 1'b0);
                if (decrypt_on) begin
                    drop_message();
                    phase = PH_TAG;
                end else begin
                    owe(lanes[3], ascon_pkg::RATE_BYTES, ascon_pkg::KIND_TAG, 1'b0, 1'b0);
                    owe(lanes[4], ascon_pkg::RATE_BYTES, ascon_pkg::KIND_TAG, 1'b1, 1'b0);
                    drop_message();
                end
            end
        end else if (fn == ascon_pkg::FN_TAG && phase == PH_TAG) begin
            if (!first_tag_seen) begin
                tag_differs = (data != lanes[3]);
                first_tag_seen = 1'b1;
            end else begin
                if (data != lanes[4]) begin
                    tag_differs = 1'b1;
                end
                owe(64'd0, 4'd0, ascon_pkg::KIND_VERDICT, 1'b1, !tag_differs);
                drop_message();
            end
        end else begin
            owe(64'd0, 4'd0, ascon_pkg::KIND_SEQERR, 1'b1, 1'b0);
            drop_message();
        end
    endfunction

    function automatic void report(input string what, input ascon_pkg::t_result want,
                                   input ascon_pkg::t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected data %h bytes %0d kind %0d last %0b ok %0b", what,
                     want.data, want.bytes, want.kind, want.last, want.ok);
            $display("    got data %h bytes %0d kind %0d last %0b ok %0b",
                     got.data, got.bytes, got.kind, got.last, got.ok);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        ascon_pkg::t_result got;
        ascon_pkg::t_result want;
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
            nonce_hi = '0;
            nonce_lo = '0;
            decrypt_on = 1'b0;
            lanes = '0;
            drop_message();
            due_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.data = i_m_tdata[63:0];
                got.bytes = i_m_tdata[67:64];
                got.ok = i_m_tdata[68];
                got.kind = i_m_tuser;
                got.last = i_m_tlast;
                if (due_results.size() == 0) begin
                    report("result beat with nothing due", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got.data !== want.data || got.bytes !== want.bytes ||
                        got.kind !== want.kind || got.last !== want.last ||
                        got.ok !== want.ok) begin
                        report("result beat differs", want, got);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                ascon_absorb(i_s_tuser, i_s_tdata[63:0], i_s_tdata[66:64], i_s_tlast);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ascon_pkg::CFG_KEY_HIGH:   key_hi = i_cfg_data;
                    ascon_pkg::CFG_KEY_LOW:    key_lo = i_cfg_data;
                    ascon_pkg::CFG_NONCE_HIGH: nonce_hi = i_cfg_data;
                    ascon_pkg::CFG_NONCE_LOW:  nonce_lo = i_cfg_data;
                    ascon_pkg::CFG_DECRYPT:    decrypt_on = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatch_count;
        o_outstanding <= due_results.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the Ascon-128 AEAD engine testbench: clock, reset, register writes, input beats in
// random bursts and a stalling output side; all checking lives in ascon_aead_checker.
// Depends on rtl/core/ascon_pkg.sv, the engine RTL and verif/ascon_aead_checker.sv.
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_BEATS = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = ascon_pkg::FN_BEGIN;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = ascon_pkg::CFG_KEY_HIGH;
    logic [63:0] cfg_data = '0;
    int          mismatches;
    int          outstanding;

    int          cycle_count = 0;
    int          burst_left = 0;
    int          beats_sent = 0;
    int          directed_beats = 0;
    int          results_seen = 0;
    int          messages = 0;
    int          stall_mode = 0;
    int          mode_cycles = 0;
    int          stall_cycles = 0;

    logic [63:0] key_h, key_l, non_h, non_l;
    logic [63:0] ad_words[$];
    logic [2:0]  ad_tail;
    logic [63:0] plain_words[$];
    logic [2:0]  text_tail;
    logic [63:0] cipher_seen[$];
    logic [63:0] tags_seen[$];

    ascon128_aead_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ascon_aead_checker aead_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The output side switches between always ready, random stalls and long stalls.
    always @(posedge clk) begin
        if (mode_cycles == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_cycles <= $urandom_range(50, 300);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        if (stall_mode == 0) begin
            m_tready <= 1'b1;
        end else if (stall_mode == 1) begin
            m_tready <= ($urandom_range(0, 2) != 0);
        end else if (stall_cycles > 0) begin
            m_tready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_cycles <= $urandom_range(1, 20);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Keeps ciphertext and tags so that a decrypt run can replay the message.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser == ascon_pkg::KIND_TEXT) begin
                cipher_seen.push_back(m_tdata[63:0]);
            end else if (m_tuser == ascon_pkg::KIND_TAG) begin
                tags_seen.push_back(m_tdata[63:0]);
            end
        end
    end

    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 64'd0;
        end
        if (r == 1) begin
            return ~64'd0;
        end
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input logic [1:0] fn, input logic [63:0] data,
                             input logic [2:0] tail, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, tail, data};
        s_tuser <= fn;
        s_tlast <= lst;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        beats_sent++;
    endtask

    // Holds the input side until every result is in, then lets the engine settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_settings(input logic [63:0] kh, input logic [63:0] kl,
                                  input logic [63:0] nh, input logic [63:0] nl,
                                  input logic dec);
        write_reg(ascon_pkg::CFG_KEY_HIGH, kh);
        write_reg(ascon_pkg::CFG_KEY_LOW, kl);
        write_reg(ascon_pkg::CFG_NONCE_HIGH, nh);
        write_reg(ascon_pkg::CFG_NONCE_LOW, nl);
        write_reg(ascon_pkg::CFG_DECRYPT, {63'd0, dec});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic compose_message();
        int n;
        ad_words.delete();
        plain_words.delete();
        if ($urandom_range(0, 2) != 0) begin
            n = $urandom_range(1, 4);
            repeat (n) ad_words.push_back(pick_word());
            ad_tail = 3'($urandom_range(0, 7));
        end
        n = $urandom_range(1, 4);
        repeat (n) plain_words.push_back(pick_word());
        text_tail = 3'($urandom_range(0, 7));
    endtask

    // In decrypt mode the ciphertext and tags of the preceding encrypt run are sent back.
    task automatic send_message(input bit decrypting, input int corrupt_tag);
        int i;
        logic [63:0] word;
        logic lst;
        messages++;
        if (!decrypting) begin
            cipher_seen.delete();
            tags_seen.delete();
        end
        send_beat(ascon_pkg::FN_BEGIN, pick_word(), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
        for (i = 0; i < ad_words.size(); i++) begin
            lst = (i == ad_words.size() - 1);
            send_beat(ascon_pkg::FN_AD, ad_words[i],
                      lst ? ad_tail : 3'($urandom_range(0, 7)), lst);
        end
        for (i = 0; i < plain_words.size(); i++) begin
            lst = (i == plain_words.size() - 1);
            if (!decrypting) begin
                word = plain_words[i];
            end else if (i < cipher_seen.size()) begin
                word = cipher_seen[i] | ({$urandom, $urandom} & ~(~64'd0 << 8 * 0));
            end else begin
                word = pick_word();
            end
            send_beat(ascon_pkg::FN_TEXT, word, lst ? text_tail : 3'($urandom_range(0, 7)),
                      lst);
        end
        if (decrypting) begin
            for (i = 0; i < 2; i++) begin
                word = (i < tags_seen.size()) ? tags_seen[i] : pick_word();
                if (i == corrupt_tag) begin
                    word = word ^ (64'd1 << $urandom_range(0, 63));
                end
                send_beat(ascon_pkg::FN_TAG, word, 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            send_beat(2'($urandom_range(0, 3)), pick_word(), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_settings('0, '0, '0, '0, 1'b0);
        send_beat(ascon_pkg::FN_TEXT, ~64'd0, 3'd7, 1'b1);
        send_beat(ascon_pkg::FN_TAG, ~64'd0, 3'd7, 1'b1);
        send_beat(ascon_pkg::FN_AD, ~64'd0, 3'd7, 1'b1);
        send_beat(ascon_pkg::FN_BEGIN, '0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_TEXT, '0, 3'd0, 1'b1);
        send_beat(ascon_pkg::FN_BEGIN, ~64'd0, 3'd7, 1'b1);
        send_beat(ascon_pkg::FN_AD, ~64'd0, 3'd7, 1'b0);
        send_beat(ascon_pkg::FN_AD, ~64'd0, 3'd7, 1'b1);
        send_beat(ascon_pkg::FN_TEXT, ~64'd0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_TEXT, '0, 3'd7, 1'b1);
        send_beat(ascon_pkg::FN_BEGIN, '0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_AD, '0, 3'd0, 1'b1);
        send_beat(ascon_pkg::FN_TEXT, ~64'd0, 3'd1, 1'b1);
        send_beat(ascon_pkg::FN_BEGIN, '0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_TEXT, ~64'd0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_AD, ~64'd0, 3'd0, 1'b1);
        send_beat(ascon_pkg::FN_BEGIN, '0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_AD, ~64'd0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_TEXT, ~64'd0, 3'd0, 1'b0);
        // Switch to decrypt in the middle of a message.
        send_beat(ascon_pkg::FN_BEGIN, '0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_TEXT, ~64'd0, 3'd0, 1'b0);
        wait_drained();
        write_settings('0, '0, '0, '0, 1'b1);
        send_beat(ascon_pkg::FN_TEXT, ~64'd0, 3'd4, 1'b1);
        send_beat(ascon_pkg::FN_TAG, '0, 3'd0, 1'b0);
        send_beat(ascon_pkg::FN_TAG, ~64'd0, 3'd0, 1'b0);
        wait_drained();
        write_settings(~64'd0, ~64'd0, ~64'd0, ~64'd0, 1'b1);
        send_beat(ascon_pkg::FN_BEGIN, ~64'd0, 3'd7, 1'b1);
        send_beat(ascon_pkg::FN_TEXT, ~64'd0, 3'd5, 1'b1);
        send_beat(ascon_pkg::FN_AD, ~64'd0, 3'd7, 1'b1);
        directed_beats = beats_sent;

        while (beats_sent - directed_beats < RANDOM_BEATS) begin
            wait_drained();
            key_h = pick_word();
            key_l = pick_word();
            non_h = pick_word();
            non_l = pick_word();
            write_settings(key_h, key_l, non_h, non_l, 1'b0);
            compose_message();
            send_message(1'b0, -1);
            if ($urandom_range(0, 3) == 0) begin
                send_noise();
            end
            if ($urandom_range(0, 2) != 0) begin
                wait_drained();
                write_settings(key_h, key_l, non_h, non_l, 1'b1);
                send_message(1'b1, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1) : -1);
                if ($urandom_range(0, 4) == 0) begin
                    send_noise();
                end
            end
        end

        wait_drained();
        $display("Sent %0d input beats in %0d messages (%0d random), %0d result beats checked.",
                 beats_sent, messages, beats_sent - directed_beats, results_seen);
        $display("Encrypt and decrypt ran with extreme and random keys, bad tags and stray items.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== ascon128_aead_engine.f =====
rtl/core/ascon_pkg.sv
rtl/core/ascon128_aead_engine.sv
verif/ascon_aead_checker.sv
verif/testbench.sv
